>>> src/lppd_pkg.sv
// Shared types and constants for the length-prefixed packet deframer.
// No dependencies; every module of the block imports this package.
package lppd_pkg;

  localparam int unsigned HDR_BYTES     = 6;
  localparam logic [15:0] MAX_BODY_RST  = 16'd4096;
  localparam int unsigned PADDR_W       = 3;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_MAX_BODY = 1'b0,
    REG_NONE     = 1'b1
  } lppd_reg_t;

  typedef enum logic [1:0] {
    ST_BODY      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_MALFORMED = 2'd2
  } lppd_status_t;

  typedef struct packed {
    lppd_status_t status;
    logic [15:0]  packet_opcode;
    logic [7:0]   body_byte;
    logic         last;
  } lppd_result_t;

  // Parser status seen by the top level
  typedef struct packed {
    logic failed;
    logic in_body;
  } lppd_ctl_t;

endpackage

>>> src/lppd_parser.sv
// Header/body parser: collects the six header bytes, checks the length and
// tags body bytes. Depends on lppd_pkg.
module lppd_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_fire,
  input  logic [7:0]            rx_byte,
  input  logic [15:0]           max_body,
  output logic                  res_valid,
  output lppd_pkg::lppd_result_t res,
  output lppd_pkg::lppd_ctl_t   ctl
);
  import lppd_pkg::*;

  logic [2:0]  hdr_cnt_r,  hdr_cnt_nxt;
  logic [39:0] hdr_shift_r, hdr_shift_nxt;
  logic [31:0] body_rem_r, body_rem_nxt;
  logic [15:0] opcode_r,   opcode_nxt;
  logic        in_body_r,  in_body_nxt;
  logic        failed_r,   failed_nxt;
  logic [31:0] hdr_len;
  logic [15:0] hdr_op;

  assign hdr_len = hdr_shift_r[31:0];
  assign hdr_op  = {rx_byte, hdr_shift_r[39:32]};

  always_comb begin
    hdr_cnt_nxt   = hdr_cnt_r;
    hdr_shift_nxt = hdr_shift_r;
    body_rem_nxt  = body_rem_r;
    opcode_nxt    = opcode_r;
    in_body_nxt   = in_body_r;
    failed_nxt    = failed_r;
    res_valid     = 1'b0;
    res           = '{status: ST_BODY, packet_opcode: opcode_r, body_byte: 8'd0, last: 1'b0};
    if (byte_fire && !failed_r) begin
      if (in_body_r) begin
        res_valid     = 1'b1;
        res.body_byte = rx_byte;
        res.last      = (body_rem_r <= 32'd1);
        if (body_rem_r <= 32'd1) begin
          body_rem_nxt = 32'd0;
          in_body_nxt  = 1'b0;
        end else begin
          body_rem_nxt = body_rem_r - 32'd1;
        end
      end else if (hdr_cnt_r != 3'(HDR_BYTES - 1)) begin
        hdr_shift_nxt[hdr_cnt_r*8 +: 8] = rx_byte;
        hdr_cnt_nxt = hdr_cnt_r + 3'd1;
      end else begin
        // Header complete: sample the limit now
        hdr_cnt_nxt       = 3'd0;
        hdr_shift_nxt     = '0;
        opcode_nxt        = hdr_op;
        res.packet_opcode = hdr_op;
        if (hdr_len > {16'd0, max_body}) begin
          failed_nxt = 1'b1;
          res_valid  = 1'b1;
          res.status = ST_MALFORMED;
          res.last   = 1'b1;
        end else if (hdr_len == 32'd0) begin
          res_valid  = 1'b1;
          res.status = ST_EMPTY;
          res.last   = 1'b1;
        end else begin
          body_rem_nxt = hdr_len;
          in_body_nxt  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r   <= '0;
      hdr_shift_r <= '0;
      body_rem_r  <= '0;
      opcode_r    <= '0;
      in_body_r   <= 1'b0;
      failed_r    <= 1'b0;
    end else begin
      hdr_cnt_r   <= hdr_cnt_nxt;
      hdr_shift_r <= hdr_shift_nxt;
      body_rem_r  <= body_rem_nxt;
      opcode_r    <= opcode_nxt;
      in_body_r   <= in_body_nxt;
      failed_r    <= failed_nxt;
    end
  end

  assign ctl = '{failed: failed_r, in_body: in_body_r};

endmodule

>>> src/lppd_out_buf.sv
// Result register with a skid stage so the input side keeps moving while
// a result waits. Depends on lppd_pkg.
module lppd_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  lppd_pkg::lppd_result_t push_data,
  output logic                   space,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lppd_pkg::lppd_result_t out_data
);
  import lppd_pkg::*;

  lppd_result_t main_r, skid_r;
  logic         main_v_r, skid_v_r;
  logic         pop;

  assign pop       = main_v_r && out_ready;
  assign space     = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) main_v_r <= 1'b1;
      else                  skid_v_r <= 1'b1;
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) main_r <= skid_r;
    end else if (push) begin
      // Load main if free or popping; else park in the skid stage
      if (!main_v_r || pop) main_r <= push_data;
      else                  skid_r <= push_data;
    end
  end

endmodule

>>> src/length_prefixed_packet_deframer.sv
// Top level of the length-prefixed packet deframer: APB register, parser and
// output buffer. Depends on lppd_pkg, lppd_parser and lppd_out_buf.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  in       | in_valid/in_ready  | in_rx_byte
//  out      | out_valid/out_ready| out_status, out_packet_opcode, out_body_byte,
//           |                    | out_last
//  config   | APB, pready high   | max_body_bytes at byte address 0
//
// One byte is taken per cycle while in_ready is high; every result is registered.
// in_ready drops only while both the result register and the skid stage hold
// results, i.e. after out_ready has been low for two results.
// Reset (synchronous, rst_n low) clears the parser and sets the limit to 4096.
// After a malformed header the block takes bytes and drops them until reset.
module length_prefixed_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_packet_opcode,
  output logic [7:0]  out_body_byte,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [lppd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lppd_pkg::*;

  logic [15:0]  max_body_r;
  logic         in_fire;
  logic         res_valid;
  lppd_result_t res, out_res;
  lppd_ctl_t    ctl;
  lppd_reg_t    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = lppd_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= MAX_BODY_RST;
    end else if (psel && penable && pwrite && reg_sel == REG_MAX_BODY) begin
      max_body_r <= pwdata[15:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAX_BODY: prdata = {16'd0, max_body_r};
      default:      prdata = 32'd0;
    endcase
  end

  assign in_fire = in_valid && in_ready;

  lppd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (in_fire),
    .rx_byte   (in_rx_byte),
    .max_body  (max_body_r),
    .res_valid (res_valid),
    .res       (res),
    .ctl       (ctl)
  );

  lppd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_status        = out_res.status;
  assign out_packet_opcode = out_res.packet_opcode;
  assign out_body_byte     = out_res.body_byte;
  assign out_last          = out_res.last;

  // Dead block never produces a result
  a_failed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.failed |-> !res_valid)
    else $error("result produced after malformed header");

  // A malformed result locks the parser
  a_malformed_locks: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status == ST_MALFORMED |=> ctl.failed)
    else $error("parser not locked after malformed header");

  // Final body byte closes the body
  a_last_ends_body: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status == ST_BODY && res.last |=> !ctl.in_body)
    else $error("body still open after last byte");

  // Back-pressure only with a result waiting
  a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule

>>> tb/tb_length_prefixed_packet_deframer.sv
// Self-checking testbench for length_prefixed_packet_deframer: directed rows, then random
// packets under three idling modes, checked against a byte-level deframing predictor.
// Depends on lppd_pkg and the deframer RTL only.
module tb_length_prefixed_packet_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import lppd_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 64;
  localparam int unsigned PHASE_ITEMS   = 150;
  localparam int unsigned CYCLE_LIMIT   = 500_000;

  typedef enum logic [1:0] {
    RK_PRED,   // byte, checked against the predictor
    RK_QUIET,  // byte, no result allowed
    RK_RES,    // byte, result typed into the row
    RK_WRITE   // register write
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [31:0]          val;
    logic [PADDR_W-1:0]   addr;
    lppd_result_t         want;
  } step_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_rx_byte;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic [15:0]        out_packet_opcode;
  logic [7:0]         out_body_byte;
  logic               out_last;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  length_prefixed_packet_deframer dut (.*);

  // Predictor state and register copy
  logic [15:0] lim;
  int          hdr_cnt;
  logic [47:0] hdr_bytes;
  logic [31:0] body_left;
  logic [15:0] cur_op;
  logic        in_pkt;
  logic        dead;

  lppd_result_t due_results[$];
  step_t        plan[$];
  row_kind_t    step_kind;
  lppd_result_t step_want;
  int unsigned  snd_gap_pct;
  int unsigned  rcv_stall_pct;
  int unsigned  sent;
  int unsigned  errors;
  int unsigned  cycles;
  int unsigned  hold_reqs;
  int unsigned  holds_done;
  int unsigned  hold_left;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic lppd_result_t mk_result(lppd_status_t st, logic [15:0] op,
                                             logic [7:0] b, logic l);
    mk_result = '{status: st, packet_opcode: op, body_byte: b, last: l};
  endfunction

  // Advance the deframer state by one byte; return 1 when a result is produced
  function automatic bit deframe_byte(input logic [7:0] b, output lppd_result_t r);
    logic [31:0] len;
    r = '0;
    if (dead) return 1'b0;
    if (in_pkt) begin
      r = mk_result(ST_BODY, cur_op, b, body_left <= 1);
      if (body_left != 0) body_left = body_left - 1;
      if (body_left == 0) in_pkt = 1'b0;
      return 1'b1;
    end
    hdr_bytes[8*hdr_cnt +: 8] = b;
    hdr_cnt++;
    if (hdr_cnt < HDR_BYTES) return 1'b0;
    len       = hdr_bytes[31:0];
    cur_op    = hdr_bytes[47:32];
    hdr_cnt   = 0;
    hdr_bytes = '0;
    if (len > {16'h0, lim}) begin
      dead = 1'b1;
      r = mk_result(ST_MALFORMED, cur_op, 8'h00, 1'b1);
      return 1'b1;
    end
    if (len == 0) begin
      r = mk_result(ST_EMPTY, cur_op, 8'h00, 1'b1);
      return 1'b1;
    end
    body_left = len;
    in_pkt    = 1'b1;
    return 1'b0;
  endfunction

  function automatic void cmp(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  // Predict on every accepted byte, then check every accepted result
  always @(posedge clk) begin : scoreboard
    lppd_result_t r;
    bit           got;
    if (rst_n && in_valid && in_ready) begin
      got = deframe_byte(in_rx_byte, r);
      case (step_kind)
        RK_RES:   due_results.push_back(step_want);
        RK_QUIET: ;
        default:  if (got) due_results.push_back(r);
      endcase
    end
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got status %0d opcode %0h",
                 $time, out_status, out_packet_opcode,
                 " byte %0h last %0b", out_body_byte, out_last);
      end else begin
        r = due_results.pop_front();
        cmp("status", 32'(r.status), 32'(out_status));
        cmp("packet_opcode", 32'(r.packet_opcode), 32'(out_packet_opcode));
        cmp("body_byte", 32'(r.body_byte), 32'(out_body_byte));
        cmp("last", 32'(r.last), 32'(out_last));
      end
    end
  end

  // Result sink: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_reqs != holds_done) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance, valid still high
  task automatic push_byte(input logic [7:0] b, input row_kind_t kind,
                           input lppd_result_t want = '0);
    while ($urandom_range(99) < snd_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    step_kind = kind;
    step_want = want;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every expected result has come, then let the parser settle
  task automatic drain();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] addr,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_limit(input logic [PADDR_W-1:0] addr, input logic [31:0] val);
    logic [31:0] rd;
    drain();
    apb_xfer(1'b1, addr, val, rd);
    if (lppd_reg_t'(addr[2]) == REG_MAX_BODY) lim = val[15:0];
    apb_xfer(1'b0, {REG_MAX_BODY, 2'b00}, 32'h0, rd);
    cmp("max_body_bytes readback", {16'h0, lim}, rd);
  endtask

  task automatic send_packet(input logic [31:0] len, input logic [15:0] op);
    for (int i = 0; i < 4; i++) push_byte(len[8*i +: 8], RK_PRED);
    push_byte(op[7:0], RK_PRED);
    push_byte(op[15:8], RK_PRED);
    for (int unsigned i = 0; i < len; i++) push_byte(8'($urandom), RK_PRED);
  endtask

  // Mostly short bodies, some empty, a few long ones or exactly at the limit
  function automatic logic [31:0] pick_len(input logic [15:0] cap);
    int unsigned c;
    c = $urandom_range(99);
    if (cap == 0 || c < 10) return 32'd0;
    if (c < 15 && cap <= 300) return {16'h0, cap};
    if (c < 20) return $urandom_range(1, (cap < 300) ? cap : 300);
    return $urandom_range(1, (cap < 16) ? cap : 16);
  endfunction

  function automatic logic [15:0] lim_for(input int idx);
    case (idx)
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 64));
      3:       return 16'd1;
      4:       return MAX_BODY_RST;
      5:       return 16'($urandom_range(65, 65535));
      6:       return 16'($urandom_range(2, 300));
      7:       return 16'd0;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic void add_row(row_kind_t k, logic [31:0] v, lppd_result_t w = '0,
                                  logic [PADDR_W-1:0] a = {REG_MAX_BODY, 2'b00});
    plan.push_back('{kind: k, val: v, addr: a, want: w});
  endfunction

  function automatic void add_header(logic [31:0] len, logic [15:0] op, row_kind_t tail,
                                     lppd_result_t w = '0);
    logic [47:0] hdr;
    hdr = {op, len};
    for (int i = 0; i < 5; i++) add_row(RK_QUIET, hdr[8*i +: 8]);
    add_row(tail, hdr[47:40], w);
  endfunction

  initial begin
    logic [31:0] len;
    logic [15:0] op;
    int unsigned stop_at;
    clk = 1'b0; rst_n = 1'b0;
    in_valid = 1'b0; in_rx_byte = 8'h00; out_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = 32'h0;
    step_kind = RK_PRED; step_want = '0;
    lim = MAX_BODY_RST; hdr_cnt = 0; hdr_bytes = '0; body_left = '0;
    cur_op = '0; in_pkt = 1'b0; dead = 1'b0;
    sent = 0; errors = 0; cycles = 0; hold_reqs = 0; holds_done = 0; hold_left = 0;
    snd_gap_pct = 33; rcv_stall_pct = 83;

    // Only the low 16 bits stick; a write to the unused index is dropped
    add_row(RK_WRITE, 32'h0001_0002);
    add_row(RK_WRITE, 32'h0000_0000, '0, {REG_NONE, 2'b00});
    // Body length equal to the limit, extreme byte values
    add_header(32'd2, 16'hFFFF, RK_QUIET);
    add_row(RK_RES, 32'hFF, mk_result(ST_BODY, 16'hFFFF, 8'hFF, 1'b0));
    add_row(RK_RES, 32'h00, mk_result(ST_BODY, 16'hFFFF, 8'h00, 1'b1));
    // Lower the limit mid-body: the packet in progress is unaffected
    add_header(32'd2, 16'h8001, RK_QUIET);
    add_row(RK_PRED, 32'hA5);
    add_row(RK_WRITE, 32'h0000_0000);
    add_row(RK_PRED, 32'h5A);
    add_header(32'd0, 16'h1234, RK_RES, mk_result(ST_EMPTY, 16'h1234, 8'h00, 1'b1));

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == RK_WRITE) set_limit(plan[i].addr, plan[i].val);
      else push_byte(plan[i].val[7:0], plan[i].kind, plan[i].want);
    end

    for (int m = 0; m < 3; m++) begin
      snd_gap_pct   = (m == 0) ? 33 : (m == 1) ? 83 : 0;
      rcv_stall_pct = (m == 0) ? 83 : (m == 1) ? 33 : 0;
      for (int s = 0; s < 3; s++) begin
        if ($urandom_range(1)) set_limit({REG_NONE, 2'b00}, $urandom);
        set_limit({REG_MAX_BODY, 2'b00},
                  {16'($urandom_range(0, 65535)), lim_for(3*m + s)});
        if (lim >= 40) begin
          // Hold the result side off while a long body keeps coming
          hold_reqs++;
          send_packet(32'd40, 16'($urandom));
        end
        stop_at = sent + PHASE_ITEMS;
        while (sent < stop_at) send_packet(pick_len(lim), 16'($urandom));
      end
    end

    // Oversized length kills the block; everything after it is dropped
    set_limit({REG_MAX_BODY, 2'b00}, $urandom_range(0, 65535));
    if ($urandom_range(1)) len = {16'h0, lim} + 32'd1;
    else len = {8'($urandom_range(1, 255)), 24'($urandom)};
    op = 16'($urandom);
    for (int i = 0; i < 4; i++) push_byte(len[8*i +: 8], RK_PRED);
    push_byte(op[7:0], RK_PRED);
    push_byte(op[15:8], RK_RES, mk_result(ST_MALFORMED, op, 8'h00, 1'b1));
    repeat (30) push_byte(8'($urandom), RK_QUIET);
    set_limit({REG_MAX_BODY, 2'b00}, 32'h0000_FFFF);
    repeat (6) push_byte(8'h00, RK_QUIET);
    repeat (10) push_byte(8'($urandom), RK_QUIET);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
